// ----- hdl/ssr_pkg.sv -----
// Shared types, codes and a helper function for the speed spike repair unit.
package ssr_pkg;

  // Field widths
  localparam int SW    = 16;
  localparam int OP_W  = 2;
  localparam int IDX_W = 10;
  localparam int ST_W  = 2;
  localparam int PCT_W = 7;
  localparam int CFG_IW = 3;
  localparam int WIN   = 5;

  // Default sizing
  localparam int DEF_MAX_SAMPLES = 1024;
  localparam int DEF_MIN_SERIES  = 5;

  // Percent scale for the relative tests
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  // Opcodes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Register indexes
  localparam logic [CFG_IW-1:0] CFG_ZERO_FLOOR = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ISO_ABS    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_ISO_PCT    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ISO_FLOOR  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_MED_ABS    = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_MED_PCT    = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_MED_FLOOR  = 3'd6;

  // Register reset values
  localparam logic [SW-1:0]    RST_ZERO_FLOOR = 16'd160;
  localparam logic [SW-1:0]    RST_ISO_ABS    = 16'd128;
  localparam logic [PCT_W-1:0] RST_ISO_PCT    = 7'd8;
  localparam logic [SW-1:0]    RST_ISO_FLOOR  = 16'd16;
  localparam logic [SW-1:0]    RST_MED_ABS    = 16'd240;
  localparam logic [PCT_W-1:0] RST_MED_PCT    = 7'd10;
  localparam logic [SW-1:0]    RST_MED_FLOOR  = 16'd16;

  // Centre position updates
  localparam int CEN_W = 3;
  localparam logic [CEN_W-1:0] CEN_HOLD = 3'd0;
  localparam logic [CEN_W-1:0] CEN_IDX  = 3'd1;
  localparam logic [CEN_W-1:0] CEN_DEC  = 3'd2;
  localparam logic [CEN_W-1:0] CEN_NEXT = 3'd3;
  localparam logic [CEN_W-1:0] CEN_INC  = 3'd4;

  // Result selection
  localparam int RES_W = 3;
  localparam logic [RES_W-1:0] RES_ZERO = 3'd0;
  localparam logic [RES_W-1:0] RES_FULL = 3'd1;
  localparam logic [RES_W-1:0] RES_OOR  = 3'd2;
  localparam logic [RES_W-1:0] RES_RAW  = 3'd3;
  localparam logic [RES_W-1:0] RES_FIX  = 3'd4;

  localparam int OFF_W = 3;
  localparam logic [OFF_W-1:0] WIN_LAST = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [SW-1:0]    sample;
    logic [IDX_W-1:0] index;
  } in_word_t;

  typedef struct packed {
    logic [SW-1:0]   value;
    logic            was_spike;
    logic [ST_W-1:0] status;
  } out_word_t;

  typedef struct packed {
    logic             cap_in;
    logic             app_wr;
    logic             clr;
    logic [CEN_W-1:0] cen_op;
    logic             rd_en;
    logic [OFF_W-1:0] rd_off;
    logic             ev1;
    logic             ev2;
    logic             ev3;
    logic             set_left;
    logic             set_right;
    logic             mul;
    logic             sum;
    logic             div_start;
    logic             res_ld;
    logic [RES_W-1:0] res_sel;
    logic             out_ld;
  } ssr_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            oor;
    logic            spike;
    logic            div_done;
  } ssr_sts_t;

  // Median of five through a nine-exchange sorting network
  function automatic logic [SW-1:0] median5(input logic [WIN-1:0][SW-1:0] win);
    logic [WIN-1:0][SW-1:0] v;
    logic [SW-1:0] t;
    v = win;
    if (v[0] > v[3]) begin t = v[0]; v[0] = v[3]; v[3] = t; end
    if (v[1] > v[4]) begin t = v[1]; v[1] = v[4]; v[4] = t; end
    if (v[0] > v[2]) begin t = v[0]; v[0] = v[2]; v[2] = t; end
    if (v[1] > v[3]) begin t = v[1]; v[1] = v[3]; v[3] = t; end
    if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
    if (v[2] > v[4]) begin t = v[2]; v[2] = v[4]; v[4] = t; end
    if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
    if (v[3] > v[4]) begin t = v[3]; v[3] = v[4]; v[4] = t; end
    if (v[2] > v[3]) begin t = v[2]; v[2] = v[3]; v[3] = t; end
    return v[2];
  endfunction

endpackage

// ----- hdl/speed_spike_repair_unit.sv -----
// Top level of the speed spike repair unit: controller plus datapath.
//
//   port group | direction | handshake           | word
//   in_        | input     | in_valid / in_stall   | opcode, sample, index
//   out_       | output    | out_valid / out_stall | value, was_spike, status
//   cfg_       | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Append, clear and out-of-range reads pass through the decode and done states to the output.
// A read of a sample that is not a spike loads the window and runs the spike tests;
// a spike read also loads and tests a window for each anchor test, then runs the divider, NW bits wide
// (29 at 1024 samples): each test reloads five store words over the one read port.
// Reset is synchronous; the store content is left as is, only the count clears.
// A new word is taken once the previous one is finished, even while its result
// still waits in the output register under stall.
module speed_spike_repair_unit import ssr_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int MIN_SERIES  = DEF_MIN_SERIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [SW-1:0]     cfg_data
);

  ssr_cmd_t cmd;
  ssr_sts_t sts;

  ssr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssr_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MIN_SERIES  (MIN_SERIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- hdl/ssr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ssr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ssr_div.sv -----
// Restoring divider, one quotient bit per cycle.
module ssr_div #(
  parameter int NW = 29,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quo,
  output logic          done
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW-1:0]   rem_r;
  logic [NW-1:0]   q_r;
  logic [DW:0]     trial;
  logic            ge;
  logic [DW-1:0]   rem_nxt;
  logic [NW-1:0]   q_nxt;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, q_r[NW-1]};
    ge      = (trial >= {1'b0, divisor});
    rem_nxt = ge ? DW'(trial - {1'b0, divisor}) : DW'(trial);
    q_nxt   = {q_r[NW-2:0], ge};
  end

  // Control: count the steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule

// ----- hdl/ssr_dp.sv -----
// Datapath: sample store, window, spike tests, anchors and interpolation.
module ssr_dp import ssr_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int MIN_SERIES  = DEF_MIN_SERIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_word_t          in_data,
  output out_word_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [SW-1:0]     cfg_data,
  input  ssr_cmd_t          cmd,
  output ssr_sts_t          sts
);

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int XW  = (CW > IDX_W) ? CW : IDX_W;
  localparam int PW  = SW + CW;
  localparam int NW  = SW + CW + 2;
  localparam int DVW = CW + 1;
  localparam int MW1 = SW + 1 + PCT_W;
  localparam int MW2 = SW + PCT_W;

  // Latched word and counters
  in_word_t          in_r;
  logic [CW-1:0]     count_r;
  logic [AW-1:0]     cen_r;
  logic              rd_q_r;

  // Registers
  logic [SW-1:0]     zfloor_r;
  logic [SW-1:0]     iso_abs_r;
  logic [PCT_W-1:0]  iso_pct_r;
  logic [SW-1:0]     iso_floor_r;
  logic [SW-1:0]     med_abs_r;
  logic [PCT_W-1:0]  med_pct_r;
  logic [SW-1:0]     med_floor_r;

  // Window and test stages
  logic [WIN-1:0][SW-1:0] w_r;
  logic [SW-1:0]     med_r;
  logic [SW:0]       d2_r;
  logic [SW:0]       sum_r;
  logic              ext_r;
  logic              zero_r;
  logic              bok_r;
  logic              mok_r;
  logic              iso_r;
  logic [SW-1:0]     diff_r;
  logic              spike_r;

  // Anchors and interpolation
  logic [AW-1:0]     lpos_r;
  logic [AW-1:0]     rpos_r;
  logic [SW-1:0]     lv_r;
  logic [SW-1:0]     rv_r;
  logic [PW-1:0]     p1_r;
  logic [PW-1:0]     p2_r;
  logic              up_r;
  logic [NW-1:0]     dvd_r;
  out_word_t         res_r;
  out_word_t         out_r;

  logic [AW-1:0]     idx_pos;
  logic [AW-1:0]     rd_addr;
  logic [SW-1:0]     rd_data;
  logic [SW-1:0]     prev;
  logic [SW-1:0]     cur;
  logic [SW-1:0]     next;
  logic [SW:0]       two_cur;
  logic [SW:0]       sum_c;
  logic [SW:0]       d2_c;
  logic [CW-1:0]     cen_w;
  logic [MW1-1:0]    d2_x;
  logic [MW1-1:0]    iso_px;
  logic              iso_hit;
  logic [MW2-1:0]    diff_x;
  logic [MW2-1:0]    med_px;
  logic              med_hit;
  logic [CW-1:0]     den;
  logic [CW-1:0]     num;
  logic [SW-1:0]     adiff;
  logic [PW-1:0]     total;
  logic [NW-1:0]     quo;
  logic              div_done;

  assign idx_pos = AW'(in_r.index);
  assign rd_addr = cen_r + AW'(cmd.rd_off) - AW'(2);
  assign prev    = w_r[1];
  assign cur     = w_r[2];
  assign next    = w_r[3];
  assign cen_w   = CW'(cen_r);

  ssr_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.app_wr),
    .waddr (AW'(count_r)),
    .wdata (in_r.sample),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zfloor_r    <= RST_ZERO_FLOOR;
      iso_abs_r   <= RST_ISO_ABS;
      iso_pct_r   <= RST_ISO_PCT;
      iso_floor_r <= RST_ISO_FLOOR;
      med_abs_r   <= RST_MED_ABS;
      med_pct_r   <= RST_MED_PCT;
      med_floor_r <= RST_MED_FLOOR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ZERO_FLOOR: zfloor_r    <= cfg_data;
        CFG_ISO_ABS:    iso_abs_r   <= cfg_data;
        CFG_ISO_PCT:    iso_pct_r   <= cfg_data[PCT_W-1:0];
        CFG_ISO_FLOOR:  iso_floor_r <= cfg_data;
        CFG_MED_ABS:    med_abs_r   <= cfg_data;
        CFG_MED_PCT:    med_pct_r   <= cfg_data[PCT_W-1:0];
        CFG_MED_FLOOR:  med_floor_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sample count and read-pending flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rd_q_r  <= 1'b0;
    end else begin
      rd_q_r <= cmd.rd_en;
      if (cmd.clr) begin
        count_r <= '0;
      end else if (cmd.app_wr) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // Latch the input word and move the window centre
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_r <= in_data;
    end
    case (cmd.cen_op)
      CEN_IDX:  cen_r <= idx_pos;
      CEN_DEC:  cen_r <= cen_r - AW'(1);
      CEN_NEXT: cen_r <= idx_pos + AW'(1);
      CEN_INC:  cen_r <= cen_r + AW'(1);
      default: ;
    endcase
  end

  // Advance the window as store words come back
  always_ff @(posedge clk) begin
    if (rd_q_r) begin
      w_r <= {rd_data, w_r[WIN-1:1]};
    end
  end

  // First test stage: median, neighbour sum, deviation, and the extreme, zero and bound flags
  always_comb begin
    two_cur = {cur, 1'b0};
    sum_c   = {1'b0, prev} + {1'b0, next};
    d2_c    = (two_cur > sum_c) ? (two_cur - sum_c) : (sum_c - two_cur);
  end

  always_ff @(posedge clk) begin
    if (cmd.ev1) begin
      med_r  <= median5(w_r);
      d2_r   <= d2_c;
      sum_r  <= sum_c;
      ext_r  <= ((cur > prev) && (cur > next)) || ((cur < prev) && (cur < next));
      zero_r <= (cur == '0) && (prev > zfloor_r) && (next > zfloor_r);
      bok_r  <= (count_r >= CW'(MIN_SERIES)) && (cen_r != '0) &&
                ((cen_w + CW'(1)) < count_r);
      mok_r  <= (cen_r >= AW'(2)) && ((cen_w + CW'(2)) < count_r);
    end
  end

  // Second test stage: isolated spike, distance from median
  always_comb begin
    d2_x    = MW1'(d2_r) * MW1'(PCT_SCALE);
    iso_px  = MW1'(iso_pct_r) * MW1'(sum_r);
    iso_hit = (d2_r > {iso_abs_r, 1'b0}) ||
              ((sum_r > {iso_floor_r, 1'b0}) && (d2_x > iso_px));
  end

  always_ff @(posedge clk) begin
    if (cmd.ev2) begin
      iso_r  <= ext_r && iso_hit;
      diff_r <= (cur > med_r) ? (cur - med_r) : (med_r - cur);
    end
  end

  // Third test stage: median test and final verdict
  always_comb begin
    diff_x  = MW2'(diff_r) * MW2'(PCT_SCALE);
    med_px  = MW2'(med_pct_r) * MW2'(med_r);
    med_hit = (med_r > med_floor_r) && (diff_r > med_abs_r) && (diff_x > med_px);
  end

  always_ff @(posedge clk) begin
    if (cmd.ev3) begin
      spike_r <= bok_r && (zero_r || iso_r || (mok_r && med_hit));
    end
  end

  // Hold the anchors
  always_ff @(posedge clk) begin
    if (cmd.set_left) begin
      lpos_r <= cen_r;
      lv_r   <= cur;
    end
    if (cmd.set_right) begin
      rpos_r <= cen_r;
      rv_r   <= cur;
    end
  end

  // Interpolation products and the rounded dividend
  always_comb begin
    den   = CW'(rpos_r) - CW'(lpos_r);
    num   = CW'(idx_pos) - CW'(lpos_r);
    adiff = (rv_r >= lv_r) ? (rv_r - lv_r) : (lv_r - rv_r);
    total = up_r ? (p1_r + p2_r) : (p1_r - p2_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p1_r <= PW'(lv_r) * PW'(den);
      p2_r <= PW'(adiff) * PW'(num);
      up_r <= (rv_r >= lv_r);
    end
    if (cmd.sum) begin
      dvd_r <= NW'({total, 1'b0}) + NW'(den);
    end
  end

  ssr_div #(
    .NW (NW),
    .DW (DVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd_r),
    .divisor  ({den, 1'b0}),
    .quo      (quo),
    .done     (div_done)
  );

  // Result word and output register
  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res_r <= '0;
      case (cmd.res_sel)
        RES_FULL: res_r.status <= ST_FULL;
        RES_OOR:  res_r.status <= ST_RANGE;
        RES_RAW:  res_r.value  <= cur;
        RES_FIX: begin
          res_r.value     <= quo[SW-1:0];
          res_r.was_spike <= 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd.out_ld) begin
      out_r <= res_r;
    end
  end

  assign out_data = out_r;

  // Status towards the controller
  always_comb begin
    sts.op       = in_r.opcode;
    sts.full     = (count_r == CW'(MAX_SAMPLES));
    sts.oor      = (XW'(in_r.index) >= XW'(count_r));
    sts.spike    = spike_r;
    sts.div_done = div_done;
  end

endmodule

// ----- hdl/ssr_ctrl.sv -----
// Controller: sequences decode, window loads, spike tests, anchor search and divide.
module ssr_ctrl import ssr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  ssr_sts_t sts,
  output ssr_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_LOAD = 4'd2;
  localparam logic [3:0] S_WAIT = 4'd3;
  localparam logic [3:0] S_EV1  = 4'd4;
  localparam logic [3:0] S_EV2  = 4'd5;
  localparam logic [3:0] S_EV3  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_SUM  = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_DIVW = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  localparam logic [1:0] P_SELF  = 2'd0;
  localparam logic [1:0] P_LEFT  = 2'd1;
  localparam logic [1:0] P_RIGHT = 2'd2;

  logic [3:0]       state_r, state_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [OFF_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        cmd.res_ld  = 1'b1;
        cmd.res_sel = RES_ZERO;
        state_nxt   = S_DONE;
        case (sts.op)
          OP_APPEND: begin
            if (sts.full) begin
              cmd.res_sel = RES_FULL;
            end else begin
              cmd.app_wr = 1'b1;
            end
          end
          OP_READ: begin
            if (sts.oor) begin
              cmd.res_sel = RES_OOR;
            end else begin
              cmd.res_ld = 1'b0;
              cmd.cen_op = CEN_IDX;
              phase_nxt  = P_SELF;
              cnt_nxt    = '0;
              state_nxt  = S_LOAD;
            end
          end
          OP_CLEAR: cmd.clr = 1'b1;
          default: ;
        endcase
      end
      S_LOAD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_off = cnt_r;
        if (cnt_r == WIN_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_WAIT;
        end else begin
          cnt_nxt = cnt_r + OFF_W'(1);
        end
      end
      S_WAIT: state_nxt = S_EV1;
      S_EV1: begin
        cmd.ev1   = 1'b1;
        state_nxt = S_EV2;
      end
      S_EV2: begin
        cmd.ev2   = 1'b1;
        state_nxt = S_EV3;
      end
      S_EV3: begin
        cmd.ev3   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        case (phase_r)
          P_SELF: begin
            if (!sts.spike) begin
              cmd.res_ld  = 1'b1;
              cmd.res_sel = RES_RAW;
              state_nxt   = S_DONE;
            end else begin
              cmd.cen_op = CEN_DEC;
              phase_nxt  = P_LEFT;
              state_nxt  = S_LOAD;
            end
          end
          P_LEFT: begin
            if (sts.spike) begin
              cmd.cen_op = CEN_DEC;
            end else begin
              cmd.set_left = 1'b1;
              cmd.cen_op   = CEN_NEXT;
              phase_nxt    = P_RIGHT;
            end
            state_nxt = S_LOAD;
          end
          default: begin
            if (sts.spike) begin
              cmd.cen_op = CEN_INC;
              state_nxt  = S_LOAD;
            end else begin
              cmd.set_right = 1'b1;
              state_nxt     = S_MUL;
            end
          end
        endcase
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_FIX;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= P_SELF;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- sim/tb_speed_spike_repair_unit.sv -----
// Testbench for the speed spike repair unit: directed table, a full-store run, then random series checked live.
module tb_speed_spike_repair_unit;
  import ssr_pkg::*;

  localparam int NSAMP = 1024;
  localparam int NRAND = 500;
  localparam int CYCLE_LIMIT = 2000000;

  // Opcode with no operation behind it
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [SW-1:0]     cfg_data;

  speed_spike_repair_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block state
  logic [SW-1:0]    speeds [NSAMP];
  int unsigned      n_speeds;
  logic [SW-1:0]    zf, iabs, ifl, mabs, mfl;
  logic [PCT_W-1:0] ipct, mpct;

  out_word_t expected_words [$];
  bit        failed;
  bit        calm;
  longint    cycles;

  // Directed table: word plus an optional typed-in answer
  typedef struct {
    in_word_t  w;
    bit        known;
    out_word_t ans;
  } dir_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles and bail out on a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("speed_spike_repair_unit regression: fail");
      $finish;
    end
  end

  function automatic longint unsigned dist_of(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic longint unsigned mid_of_five(int unsigned p);
    longint unsigned v [5];
    longint unsigned t;
    for (int a = 0; a < 5; a++) v[a] = speeds[p - 2 + a];
    for (int a = 0; a < 5; a++)
      for (int b = 0; b < 4 - a; b++)
        if (v[b] > v[b+1]) begin
          t = v[b]; v[b] = v[b+1]; v[b+1] = t;
        end
    return v[2];
  endfunction

  function automatic bit spike_at(int unsigned p);
    longint unsigned pv, cv, nv, s, d2, md, df;
    if (n_speeds < 5 || p == 0 || p + 1 >= n_speeds) return 1'b0;
    pv = speeds[p-1]; cv = speeds[p]; nv = speeds[p+1];
    if (cv == 0 && pv > zf && nv > zf) return 1'b1;
    if ((cv > pv && cv > nv) || (cv < pv && cv < nv)) begin
      s = pv + nv;
      d2 = dist_of(2 * cv, s);
      if (d2 > 2 * longint'(iabs)) return 1'b1;
      if (s > 2 * longint'(ifl) && d2 * 100 > longint'(ipct) * s) return 1'b1;
    end
    if (p >= 2 && p + 2 < n_speeds) begin
      md = mid_of_five(p);
      df = dist_of(cv, md);
      if (md > mfl && df > mabs && df * 100 > longint'(mpct) * md) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [SW-1:0] bridged_speed(int unsigned p);
    int l, r;
    longint unsigned lv, rv, den, num, tot;
    l = int'(p) - 1;
    r = int'(p) + 1;
    while (l >= 0 && spike_at(l)) l--;
    while (r < int'(n_speeds) && spike_at(r)) r++;
    if (l >= 0 && r < int'(n_speeds)) begin
      lv = speeds[l]; rv = speeds[r];
      den = r - l; num = int'(p) - l;
      if (rv >= lv) tot = lv * den + (rv - lv) * num;
      else          tot = lv * den - (lv - rv) * num;
      return SW'((2 * tot + den) / (2 * den));
    end
    if (l >= 0) return speeds[l];
    if (r < int'(n_speeds)) return speeds[r];
    return speeds[p];
  endfunction

  // Apply one word to the shadow state and return the answer
  function automatic out_word_t speed_answer(in_word_t w);
    out_word_t o;
    o = '0;
    case (w.opcode)
      OP_APPEND: begin
        if (n_speeds >= NSAMP) o.status = ST_FULL;
        else begin
          speeds[n_speeds] = w.sample;
          n_speeds++;
        end
      end
      OP_READ: begin
        if (w.index >= n_speeds) o.status = ST_RANGE;
        else if (spike_at(w.index)) begin
          o.value = bridged_speed(w.index);
          o.was_spike = 1'b1;
        end else o.value = speeds[w.index];
      end
      OP_CLEAR: n_speeds = 0;
      default: ;
    endcase
    return o;
  endfunction

  // Result side: random stall bursts, compare on acceptance
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: actual %p", $time, out_data);
        failed = 1'b1;
      end else begin
        e = expected_words.pop_front();
        if (out_data.value !== e.value)
          $display("%0t value: expected %0d actual %0d", $time, e.value, out_data.value);
        if (out_data.was_spike !== e.was_spike)
          $display("%0t was_spike: expected %0d actual %0d", $time, e.was_spike,
                   out_data.was_spike);
        if (out_data.status !== e.status)
          $display("%0t status: expected %0d actual %0d", $time, e.status, out_data.status);
        if (out_data !== e) failed = 1'b1;
      end
    end
  end

  // Drive one word; a typed-in answer replaces the predicted one
  task automatic send_word(in_word_t w, bit known = 1'b0, out_word_t ans = '0);
    out_word_t e;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = speed_answer(w);
    if (known) e = ans;
    expected_words = {expected_words, e};
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [SW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ZERO_FLOOR: zf   = d;
      CFG_ISO_ABS:    iabs = d;
      CFG_ISO_PCT:    ipct = d[PCT_W-1:0];
      CFG_ISO_FLOOR:  ifl  = d;
      CFG_MED_ABS:    mabs = d;
      CFG_MED_PCT:    mpct = d[PCT_W-1:0];
      CFG_MED_FLOOR:  mfl  = d;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_all(logic [SW-1:0] a, logic [SW-1:0] b, logic [PCT_W-1:0] c,
                           logic [SW-1:0] d, logic [SW-1:0] e, logic [PCT_W-1:0] f,
                           logic [SW-1:0] g);
    write_reg(CFG_ZERO_FLOOR, a);
    write_reg(CFG_ISO_ABS, b);
    write_reg(CFG_ISO_PCT, SW'(c));
    write_reg(CFG_ISO_FLOOR, d);
    write_reg(CFG_MED_ABS, e);
    write_reg(CFG_MED_PCT, SW'(f));
    write_reg(CFG_MED_FLOOR, g);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t mk(logic [OP_W-1:0] op, logic [SW-1:0] s, logic [IDX_W-1:0] i);
    in_word_t w;
    w.opcode = op; w.sample = s; w.index = i;
    return w;
  endfunction

  // Random opcode, the unused one included, against whatever is stored
  function automatic logic [OP_W-1:0] OP_IDX_NOISE();
    return OP_W'($urandom_range(0, 3));
  endfunction

  // Speed with occasional spikes, zero dropouts and extremes
  function automatic logic [SW-1:0] road_speed(int unsigned base);
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return SW'($urandom_range(0, 65535));
      2: return 16'hFFFF;
      3: return SW'(base + $urandom_range(200, 2000));
      default: return SW'(base + $urandom_range(0, 60));
    endcase
  endfunction

  initial begin
    dir_row_t     rows [$];
    dir_row_t     rw;
    int unsigned  sent, base, len;
    logic [SW-1:0] dir_speeds [8];

    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    failed = 1'b0; calm = 1'b0; cycles = 0; n_speeds = 0;
    zf = RST_ZERO_FLOOR; iabs = RST_ISO_ABS; ipct = RST_ISO_PCT; ifl = RST_ISO_FLOOR;
    mabs = RST_MED_ABS; mpct = RST_MED_PCT; mfl = RST_MED_FLOOR;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows: out-of-range, spare opcode, short series, zero dropout, isolated peak, extremes
    dir_speeds = '{16'd800, 16'd810, 16'd0, 16'd820, 16'hFFFF, 16'd830, 16'd840, 16'd850};
    rw.known = 1'b1; rw.ans = '0; rw.ans.status = ST_RANGE;
    rw.w = mk(OP_READ, 16'h0, 10'h3FF); rows = {rows, rw};
    rw.known = 1'b1; rw.ans = '0;
    rw.w = mk(OP_SPARE, 16'hFFFF, 10'h3FF); rows = {rows, rw};
    rw.w = mk(OP_CLEAR, 16'h0, 10'h0); rows = {rows, rw};
    for (int i = 0; i < 3; i++) begin
      rw.known = 1'b0; rw.w = mk(OP_APPEND, dir_speeds[i], 10'h0); rows = {rows, rw};
    end
    rw.known = 1'b1; rw.ans = '0; rw.ans.value = 16'd0;
    rw.w = mk(OP_READ, 16'h0, 10'd2); rows = {rows, rw};
    for (int i = 3; i < 8; i++) begin
      rw.known = 1'b0; rw.w = mk(OP_APPEND, dir_speeds[i], 10'h0); rows = {rows, rw};
    end
    for (int i = 0; i < 9; i++) begin
      rw.known = 1'b0; rw.w = mk(OP_READ, 16'h0, IDX_W'(i)); rows = {rows, rw};
    end
    rw.known = 1'b1; rw.ans = '0;
    rw.w = mk(OP_CLEAR, 16'h0, 10'h0); rows = {rows, rw};

    foreach (rows[k]) begin
      send_word(rows[k].w, rows[k].known, rows[k].ans);
    end
    drain();

    // Fill the store to the brim, overflow, read the far end
    for (int i = 0; i < NSAMP + 2; i++)
      send_word(mk(OP_APPEND, (i % 50 == 7) ? 16'd0 : SW'(1000 + (i % 13) * 3), 10'h0));
    send_word(mk(OP_READ, 16'h0, 10'h3FF));
    send_word(mk(OP_READ, 16'h0, 10'h3FE));
    send_word(mk(OP_READ, 16'h0, 10'd507));
    send_word(mk(OP_CLEAR, 16'h0, 10'h0));
    drain();

    // Random series under several register settings
    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_all(16'd0, 16'd0, 7'd0, 16'd0, 16'd0, 7'd0, 16'd0);
        1: write_all(16'hFFFF, 16'hFFFF, 7'd100, 16'hFFFF, 16'hFFFF, 7'd100, 16'hFFFF);
        2: write_all(16'd100, 16'd64, 7'd5, 16'd8, 16'd150, 7'd7, 16'd8);
        3: write_all(16'h5555, 16'hAAAA, 7'h7F, 16'h5555, 16'hAAAA, 7'h2A, 16'hAAAA);
        default: write_all(RST_ZERO_FLOOR, RST_ISO_ABS, RST_ISO_PCT, RST_ISO_FLOOR,
                           RST_MED_ABS, RST_MED_PCT, RST_MED_FLOOR);
      endcase
      if (ph == 4) calm = 1'b1;
      while (sent < (ph + 1) * NRAND / 5) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(mk(OP_IDX_NOISE(), SW'($urandom), IDX_W'($urandom)));
          sent++;
        end else begin
          send_word(mk(OP_CLEAR, SW'($urandom), IDX_W'($urandom)));
          base = $urandom_range(0, 3000);
          len = $urandom_range(3, 24);
          for (int i = 0; i < len; i++) send_word(mk(OP_APPEND, road_speed(base), IDX_W'($urandom)));
          for (int i = 0; i < len + 2; i++)
            send_word(mk(OP_READ, SW'($urandom), IDX_W'($urandom_range(0, len))));
          sent += 2 * len + 3;
        end
      end
      drain();
    end

    if (!failed && expected_words.size() == 0)
      $display("speed_spike_repair_unit regression: pass");
    else
      $display("speed_spike_repair_unit regression: fail");
    $finish;
  end

endmodule
